FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL; the enclosing module supplies
// clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Widths, pipeline timing and multiplier controls for the Rodrigues rotation
// pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpr_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int ROT_WIDTH     = 32;
    localparam int POLY_SEGMENTS = 16;

    localparam int ROT_FRAC    = ROT_WIDTH - 4;
    localparam int FB          = 55;
    localparam int HALVINGS    = 5;
    localparam int U_SHIFT     = 2 * ROT_FRAC - FB;
    localparam int WORD_WIDTH  = 64;
    localparam int PROD_WIDTH  = 2 * WORD_WIDTH;
    localparam int SHIFT_WIDTH = 6;
    localparam int RECIP_SHIFT = WORD_WIDTH - 1;

    // cross product ranges: |r x d| and |r x (r x d)|
    localparam int C1_WIDTH = ROT_WIDTH + COORD_WIDTH - ROT_FRAC + 2;
    localparam int C2_WIDTH = ROT_WIDTH + C1_WIDTH - ROT_FRAC;

    localparam logic signed [WORD_WIDTH-1:0] ONE      = 64'sd1 <<< FB;
    localparam logic signed [WORD_WIDTH-1:0] HALF_ONE = ONE >>> 1;

    // pipeline timing, in register stages from the input register
    localparam int MUL_LAT  = 5;
    localparam int ITER_LAT = 2 * MUL_LAT + 3;
    localparam int DBL_LAT  = 2 * MUL_LAT + 1;
    localparam int T_U      = MUL_LAT + 2;
    localparam int T_F      = T_U + ITER_LAT * (POLY_SEGMENTS - 1);
    localparam int T_D      = T_F + DBL_LAT * HALVINGS;
    localparam int LATENCY  = T_D + MUL_LAT + 2;
    localparam int U_DEPTH  = ITER_LAT * (POLY_SEGMENTS - 1) + DBL_LAT * (HALVINGS - 1) + 1;

    typedef struct packed {
        logic [SHIFT_WIDTH-1:0] sh;
        logic                   rnd;
    } mul_ctl_t;

    localparam mul_ctl_t CTL_SQ    = '{sh: SHIFT_WIDTH'(U_SHIFT), rnd: 1'b1};
    localparam mul_ctl_t CTL_FB    = '{sh: SHIFT_WIDTH'(FB), rnd: 1'b1};
    localparam mul_ctl_t CTL_FB1   = '{sh: SHIFT_WIDTH'(FB + 1), rnd: 1'b1};
    localparam mul_ctl_t CTL_ROT   = '{sh: SHIFT_WIDTH'(ROT_FRAC), rnd: 1'b1};
    localparam mul_ctl_t CTL_RECIP = '{sh: SHIFT_WIDTH'(RECIP_SHIFT), rnd: 1'b0};

endpackage

FILE: hw/rtl/rpr_if.sv
// ----------------------------------------------------------------------------
// rpr_in_if / rpr_out_if
// Valid/ready channels for point items and rotated results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpr_in_if import rpr_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic signed [ROT_WIDTH-1:0]   rot_x;
    logic signed [ROT_WIDTH-1:0]   rot_y;
    logic signed [ROT_WIDTH-1:0]   rot_z;

    modport source (
        output valid, point_x, point_y, point_z, center_x, center_y, center_z,
               rot_x, rot_y, rot_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, center_x, center_y, center_z,
               rot_x, rot_y, rot_z,
        output ready
    );
endinterface

interface rpr_out_if import rpr_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

FILE: hw/rtl/rotate_point_rodrigues.sv
// ----------------------------------------------------------------------------
// rotate_point_rodrigues
// Rotates a point about a centre by a rotation vector (Rodrigues' formula),
// with sin(t)/t and (1-cos t)/t^2 built from t^2 by a series and half-angle
// doublings; results saturate to the coordinate range.
// ----------------------------------------------------------------------------
//  channel  role    payload
//  item     sink    point_x/y/z, center_x/y/z (Q16.16), rot_x/y/z (Q3.28)
//  result   source  out_x/y/z (Q16.16), saturated
//
//  One item per cycle is accepted while the pipeline is not stalled; each
//  result passes the 15 series terms (13 stages each) and the 5 doubling
//  steps (11 stages each), all built from 5-stage multipliers.
//  Reset clears only the valid bits. The whole pipeline advances together;
//  while the result is held by the sink every stage holds and item.ready
//  is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rotate_point_rodrigues import rpr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    rpr_in_if.sink  item,
    rpr_out_if.source result
);

    localparam int P_DEPTH  = T_D + MUL_LAT;
    localparam int R_DEPTH  = MUL_LAT + 2;
    localparam int C1_DEPTH = T_D - T_U + 1;
    localparam int C2_DEPTH = T_D - (T_U + MUL_LAT + 1) + 1;

    localparam logic signed [WORD_WIDTH-1:0] COORD_MAX =
        (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [WORD_WIDTH-1:0] COORD_MIN = -COORD_MAX - 64'sd1;
    localparam logic signed [COORD_WIDTH-1:0] OUT_MAX = COORD_MAX[COORD_WIDTH-1:0];
    localparam logic signed [COORD_WIDTH-1:0] OUT_MIN = COORD_MIN[COORD_WIDTH-1:0];

    logic en;
    logic [LATENCY-1:0] valid_pipe_reg;

    logic signed [COORD_WIDTH-1:0] p_pipe_reg  [P_DEPTH][3];
    logic signed [COORD_WIDTH:0]   d_reg       [3];
    logic signed [ROT_WIDTH-1:0]   r_pipe_reg  [R_DEPTH][3];
    logic signed [C1_WIDTH-1:0]    c1_pipe_reg [C1_DEPTH][3];
    logic signed [C2_WIDTH-1:0]    c2_pipe_reg [C2_DEPTH][3];
    logic [WORD_WIDTH-1:0]         u_pipe_reg  [U_DEPTH];
    logic signed [WORD_WIDTH-1:0]  o_reg       [3];
    logic signed [COORD_WIDTH-1:0] out_reg     [3];
    logic                          sat_reg;

    logic signed [WORD_WIDTH-1:0] sq_w  [3];
    logic signed [WORD_WIDTH-1:0] c1a_w [3];
    logic signed [WORD_WIDTH-1:0] c1b_w [3];
    logic signed [WORD_WIDTH-1:0] c2a_w [3];
    logic signed [WORD_WIDTH-1:0] c2b_w [3];
    logic signed [WORD_WIDTH-1:0] mf1_w [3];
    logic signed [WORD_WIDTH-1:0] mf2_w [3];
    logic signed [WORD_WIDTH-1:0] ser_sum [2];
    logic signed [WORD_WIDTH-1:0] f1_w [HALVINGS+1];
    logic signed [WORD_WIDTH-1:0] f2_w [HALVINGS+1];

    logic signed [COORD_WIDTH-1:0] clip   [3];
    logic [2:0]                    clip_hit;

    // advance whenever the output stage is empty or being taken
    assign en          = !valid_pipe_reg[LATENCY-1] || result.ready;
    assign item.ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else if (en)
        begin
            valid_pipe_reg <= {valid_pipe_reg[LATENCY-2:0], item.valid};
        end
    end

    // input register, difference vector and delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_pipe_reg[0][0] <= item.point_x;
            p_pipe_reg[0][1] <= item.point_y;
            p_pipe_reg[0][2] <= item.point_z;
            d_reg[0] <= (COORD_WIDTH+1)'(item.point_x) - (COORD_WIDTH+1)'(item.center_x);
            d_reg[1] <= (COORD_WIDTH+1)'(item.point_y) - (COORD_WIDTH+1)'(item.center_y);
            d_reg[2] <= (COORD_WIDTH+1)'(item.point_z) - (COORD_WIDTH+1)'(item.center_z);
            r_pipe_reg[0][0] <= item.rot_x;
            r_pipe_reg[0][1] <= item.rot_y;
            r_pipe_reg[0][2] <= item.rot_z;
            for (int i = 1; i < P_DEPTH; i++)
            begin
                p_pipe_reg[i] <= p_pipe_reg[i-1];
            end
            for (int i = 1; i < R_DEPTH; i++)
            begin
                r_pipe_reg[i] <= r_pipe_reg[i-1];
            end
            u_pipe_reg[0] <= sq_w[0] + sq_w[1] + sq_w[2];
            for (int i = 1; i < U_DEPTH; i++)
            begin
                u_pipe_reg[i] <= u_pipe_reg[i-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                c1_pipe_reg[0][i] <= C1_WIDTH'(c1a_w[i] - c1b_w[i]);
                c2_pipe_reg[0][i] <= C2_WIDTH'(c2a_w[i] - c2b_w[i]);
            end
            for (int i = 1; i < C1_DEPTH; i++)
            begin
                c1_pipe_reg[i] <= c1_pipe_reg[i-1];
            end
            for (int i = 1; i < C2_DEPTH; i++)
            begin
                c2_pipe_reg[i] <= c2_pipe_reg[i-1];
            end
        end
    end

    // squared norm, r x d and r x (r x d)
    for (genvar i = 0; i < 3; i++) begin : g_vec
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        rpr_mul u_sq (
            .clk(clk), .en(en),
            .a(WORD_WIDTH'(r_pipe_reg[0][i])), .b(WORD_WIDTH'(r_pipe_reg[0][i])),
            .ctl(CTL_SQ), .p(sq_w[i])
        );
        rpr_mul u_c1a (
            .clk(clk), .en(en),
            .a(WORD_WIDTH'(r_pipe_reg[0][J])), .b(WORD_WIDTH'(d_reg[K])),
            .ctl(CTL_ROT), .p(c1a_w[i])
        );
        rpr_mul u_c1b (
            .clk(clk), .en(en),
            .a(WORD_WIDTH'(r_pipe_reg[0][K])), .b(WORD_WIDTH'(d_reg[J])),
            .ctl(CTL_ROT), .p(c1b_w[i])
        );
        rpr_mul u_c2a (
            .clk(clk), .en(en),
            .a(WORD_WIDTH'(r_pipe_reg[R_DEPTH-1][J])), .b(WORD_WIDTH'(c1_pipe_reg[0][K])),
            .ctl(CTL_ROT), .p(c2a_w[i])
        );
        rpr_mul u_c2b (
            .clk(clk), .en(en),
            .a(WORD_WIDTH'(r_pipe_reg[R_DEPTH-1][K])), .b(WORD_WIDTH'(c1_pipe_reg[0][J])),
            .ctl(CTL_ROT), .p(c2b_w[i])
        );
        rpr_mul u_mf1 (
            .clk(clk), .en(en),
            .a(f1_w[HALVINGS]), .b(WORD_WIDTH'(c1_pipe_reg[C1_DEPTH-1][i])),
            .ctl(CTL_FB), .p(mf1_w[i])
        );
        rpr_mul u_mf2 (
            .clk(clk), .en(en),
            .a(f2_w[HALVINGS]), .b(WORD_WIDTH'(c2_pipe_reg[C2_DEPTH-1][i])),
            .ctl(CTL_FB), .p(mf2_w[i])
        );
    end

    // series for f1 (s = 0) and f2 (s = 1) at the reduced argument
    for (genvar s = 0; s < 2; s++) begin : g_ser
        logic [WORD_WIDTH-1:0]        term_w [POLY_SEGMENTS];
        logic signed [WORD_WIDTH-1:0] sum_w  [POLY_SEGMENTS];

        assign term_w[0] = (s == 0) ? ONE : HALF_ONE;
        assign sum_w[0]  = (s == 0) ? ONE : HALF_ONE;

        for (genvar k = 1; k < POLY_SEGMENTS; k++) begin : g_term
            localparam logic [WORD_WIDTH-1:0] DIV      = WORD_WIDTH'((2*k+s) * (2*k+s+1));
            localparam logic [WORD_WIDTH-1:0] HALF_DIV = DIV / 2;
            localparam logic [WORD_WIDTH-1:0] RECIP    =
                64'h8000_0000_0000_0000 / DIV;
            localparam int  U_TAP = ITER_LAT * (k - 1);
            localparam bit  ODD   = (k % 2) == 1;

            logic signed [WORD_WIDTH-1:0] v_w, mt_w, md_w;
            logic [WORD_WIDTH-1:0]        x_pipe_reg   [MUL_LAT+1];
            logic signed [WORD_WIDTH-1:0] sum_pipe_reg [ITER_LAT-1];
            logic [WORD_WIDTH-1:0]        q0_reg, rem_reg, term_reg, term_next;
            logic signed [WORD_WIDTH-1:0] acc_reg;

            assign v_w = u_pipe_reg[U_TAP] >> (2 * HALVINGS);

            // next term before division
            rpr_mul u_mt (
                .clk(clk), .en(en), .a(term_w[k-1]), .b(v_w),
                .ctl(CTL_FB), .p(mt_w)
            );
            // quotient estimate by reciprocal, low by at most one
            rpr_mul u_md (
                .clk(clk), .en(en), .a(x_pipe_reg[0]), .b(RECIP),
                .ctl(CTL_RECIP), .p(md_w)
            );

            assign term_next = q0_reg + WORD_WIDTH'(rem_reg >= DIV);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_pipe_reg[0] <= mt_w + HALF_DIV;
                    for (int i = 1; i <= MUL_LAT; i++)
                    begin
                        x_pipe_reg[i] <= x_pipe_reg[i-1];
                    end
                    sum_pipe_reg[0] <= sum_w[k-1];
                    for (int i = 1; i < ITER_LAT - 1; i++)
                    begin
                        sum_pipe_reg[i] <= sum_pipe_reg[i-1];
                    end
                    // remainder check, then correct and accumulate
                    q0_reg   <= md_w;
                    rem_reg  <= x_pipe_reg[MUL_LAT] - md_w * DIV;
                    term_reg <= term_next;
                    acc_reg  <= ODD ? sum_pipe_reg[ITER_LAT-2] - $signed(term_next)
                                    : sum_pipe_reg[ITER_LAT-2] + $signed(term_next);
                end
            end

            assign term_w[k] = term_reg;
            assign sum_w[k]  = acc_reg;
        end

        assign ser_sum[s] = sum_w[POLY_SEGMENTS-1];
    end

    assign f1_w[0] = ser_sum[0];
    assign f2_w[0] = ser_sum[1];

    // half-angle doublings back to the full argument
    for (genvar n = 0; n < HALVINGS; n++) begin : g_dbl
        localparam int J     = HALVINGS - n;
        localparam int U_TAP = ITER_LAT * (POLY_SEGMENTS - 1) + DBL_LAT * n;

        logic signed [WORD_WIDTH-1:0] v_w, ma_w, cv_reg;
        logic signed [WORD_WIDTH-1:0] f1_pipe_reg [MUL_LAT+1];

        assign v_w = u_pipe_reg[U_TAP] >> (2 * J);

        rpr_mul u_ma (
            .clk(clk), .en(en), .a(v_w), .b(f2_w[n]), .ctl(CTL_FB), .p(ma_w)
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cv_reg         <= ONE - ma_w;
                f1_pipe_reg[0] <= f1_w[n];
                for (int i = 1; i <= MUL_LAT; i++)
                begin
                    f1_pipe_reg[i] <= f1_pipe_reg[i-1];
                end
            end
        end

        rpr_mul u_na (
            .clk(clk), .en(en), .a(f1_pipe_reg[MUL_LAT]), .b(cv_reg),
            .ctl(CTL_FB), .p(f1_w[n+1])
        );
        rpr_mul u_nb (
            .clk(clk), .en(en), .a(f1_pipe_reg[MUL_LAT]), .b(f1_pipe_reg[MUL_LAT]),
            .ctl(CTL_FB1), .p(f2_w[n+1])
        );
    end

    // clip each component to the coordinate range
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clip_hit[i] = 1'b0;
            clip[i]     = o_reg[i][COORD_WIDTH-1:0];
            if (o_reg[i] > COORD_MAX)
            begin
                clip[i]     = OUT_MAX;
                clip_hit[i] = 1'b1;
            end
            else if (o_reg[i] < COORD_MIN)
            begin
                clip[i]     = OUT_MIN;
                clip_hit[i] = 1'b1;
            end
        end
    end

    // final sum and output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o_reg[i]   <= WORD_WIDTH'(p_pipe_reg[P_DEPTH-1][i]) + mf1_w[i] + mf2_w[i];
                out_reg[i] <= clip[i];
            end
            sat_reg <= |clip_hit;
        end
    end

    assign result.valid     = valid_pipe_reg[LATENCY-1];
    assign result.out_x     = out_reg[0];
    assign result.out_y     = out_reg[1];
    assign result.out_z     = out_reg[2];
    assign result.saturated = sat_reg;

    `ASSERT_IMPLIES(a_ready_when_empty, !result.valid, item.ready,
        "input not ready while output stage is empty")
    `ASSERT_NEXT(a_freeze_on_stall, !en, $stable(valid_pipe_reg),
        "valid bits moved while pipeline stalled")
    `ASSERT_IMPLIES(a_sat_at_limit, result.valid && result.saturated,
        (result.out_x == OUT_MAX || result.out_x == OUT_MIN ||
         result.out_y == OUT_MAX || result.out_y == OUT_MIN ||
         result.out_z == OUT_MAX || result.out_z == OUT_MIN),
        "saturated flag set with no component at a limit")

endmodule

FILE: hw/rtl/rpr_mul.sv
// ----------------------------------------------------------------------------
// rpr_mul
// Five-stage signed 64x64 multiply, right shift with optional round to
// nearest (ties away from zero) and saturation of the magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpr_mul import rpr_pkg::*; (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [WORD_WIDTH-1:0] a,
    input  logic signed [WORD_WIDTH-1:0] b,
    input  mul_ctl_t                     ctl,
    output logic signed [WORD_WIDTH-1:0] p
);

    localparam int HW = WORD_WIDTH / 2;
    localparam logic [WORD_WIDTH-1:0] MAG_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

    logic [WORD_WIDTH-1:0]   ua_reg, ub_reg;
    logic                    neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    mul_ctl_t                ctl1_reg, ctl2_reg, ctl3_reg;
    logic [WORD_WIDTH-1:0]   pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [PROD_WIDTH-1:0]   prod_reg;
    logic [WORD_WIDTH-2:0]   mag_reg;
    logic                    ovf_reg;
    logic signed [WORD_WIDTH-1:0] p_reg;

    logic [PROD_WIDTH-1:0]   rounded, shifted;
    logic [WORD_WIDTH-1:0]   mag_sel;

    // round and shift the exact product
    always_comb
    begin
        rounded = prod_reg;
        if (ctl3_reg.rnd && (ctl3_reg.sh != '0))
        begin
            rounded = prod_reg + (PROD_WIDTH'(1) << (ctl3_reg.sh - SHIFT_WIDTH'(1)));
        end
        shifted = rounded >> ctl3_reg.sh;
        mag_sel = ovf_reg ? MAG_MAX : {1'b0, mag_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes and result sign
            ua_reg   <= a[WORD_WIDTH-1] ? (~a + 1'b1) : a;
            ub_reg   <= b[WORD_WIDTH-1] ? (~b + 1'b1) : b;
            neg1_reg <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
            ctl1_reg <= ctl;
            // partial products
            pp00_reg <= {{HW{1'b0}}, ua_reg[HW-1:0]} * {{HW{1'b0}}, ub_reg[HW-1:0]};
            pp01_reg <= {{HW{1'b0}}, ua_reg[HW-1:0]} * {{HW{1'b0}}, ub_reg[WORD_WIDTH-1:HW]};
            pp10_reg <= {{HW{1'b0}}, ua_reg[WORD_WIDTH-1:HW]} * {{HW{1'b0}}, ub_reg[HW-1:0]};
            pp11_reg <= {{HW{1'b0}}, ua_reg[WORD_WIDTH-1:HW]} *
                        {{HW{1'b0}}, ub_reg[WORD_WIDTH-1:HW]};
            neg2_reg <= neg1_reg;
            ctl2_reg <= ctl1_reg;
            // full product
            prod_reg <= {{WORD_WIDTH{1'b0}}, pp00_reg}
                      + {{HW{1'b0}}, pp01_reg, {HW{1'b0}}}
                      + {{HW{1'b0}}, pp10_reg, {HW{1'b0}}}
                      + {pp11_reg, {WORD_WIDTH{1'b0}}};
            neg3_reg <= neg2_reg;
            ctl3_reg <= ctl2_reg;
            // shifted magnitude and overflow
            mag_reg  <= shifted[WORD_WIDTH-2:0];
            ovf_reg  <= |shifted[PROD_WIDTH-1:WORD_WIDTH-1];
            neg4_reg <= neg3_reg;
            // clip and apply sign
            p_reg    <= neg4_reg ? -$signed(mag_sel) : $signed(mag_sel);
        end
    end

    assign p = p_reg;

endmodule
